// File: rtl/refcounted_block_free_list_top_assert.svh
// assertion macros for the block free list allocator
// used by refcounted_block_free_list_top; expects clk and rst in scope
`ifndef REFCOUNTED_BLOCK_FREE_LIST_TOP_ASSERT_SVH
`define REFCOUNTED_BLOCK_FREE_LIST_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RBFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbfl assertion failed");
// next-cycle implication
`define RBFL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbfl assertion failed");
`else
`define RBFL_ASSERT_NOW(label, ante, cons)
`define RBFL_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/rbfl_pkg.sv
// shared types and codes for the block free list allocator
// no dependencies
package rbfl_pkg;
  localparam int FUNC_W = 3;
  localparam int BLK_W  = 10;
  localparam int CNT_W  = 5;
  localparam int REFO_W = 8;
  localparam int FREE_W = 11;
  localparam int ST_W   = 3;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLAIM   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SHARE   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_PIN     = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_UNPIN   = 3'd5;

  localparam logic [ST_W-1:0] STAT_OK       = 3'd0;
  localparam logic [ST_W-1:0] STAT_NO_FREE  = 3'd1;
  localparam logic [ST_W-1:0] STAT_RANGE    = 3'd2;
  localparam logic [ST_W-1:0] STAT_NOT_OWN  = 3'd3;
  localparam logic [ST_W-1:0] STAT_PINNED   = 3'd4;
  localparam logic [ST_W-1:0] STAT_OVERFLOW = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BLK_W-1:0]  block_index;
    logic [CNT_W-1:0]  alloc_count;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0]  granted_block;
    logic [REFO_W-1:0] refs_after;
    logic [FREE_W-1:0] free_blocks;
    logic [ST_W-1:0]   status;
    logic              last;
  } rsp_t;
endpackage

// File: rtl/rbfl_stream_if.sv
// valid/ready stream channel with a typed payload
// payload types come from rbfl_pkg
interface rbfl_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rbfl_ram.sv
// generic single write, single read ram with registered read
// no dependencies
module rbfl_ram #(
  parameter int W = 8,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/refcounted_block_free_list_top.sv
// reference counted block allocator with an ordered free list
// depends on rbfl_pkg, rbfl_stream_if, rbfl_ram and the assertion header
//
// req carries one operation (alloc, claim, share, release, pin, unpin);
// rsp returns one result per allocated block for alloc, one result
// otherwise, with last set on the final one. a req transfer is taken only
// while the block is idle; it is busy until its final result is loaded.
// after rst a clearing pass over all POOL_SIZE entries builds the ascending
// free chain in the link memories; req.ready stays low during it.
// an error decided from the request alone is loaded in the error state once
// the result register is free; claim/share/release/pin/unpin read the
// block's entry while idle and commit in the execute state when the result
// is loaded. alloc reads the head's next link once per cycle unless rsp stalls.
// the per-block state lives in three single-port-read memories (info,
// next link, prev link); one memory read per cycle sets the rate.
// the result register parts the two sides: when rsp stalls, the sequencer
// holds its step and re-reads the same entry until the result is taken.
module refcounted_block_free_list_top #(
  parameter int POOL_SIZE = 1024,
  parameter int MAX_ALLOC = 16,
  parameter int REF_WIDTH = 8
) (
  input logic          clk,
  input logic          rst,
  rbfl_stream_if.sink  req,
  rbfl_stream_if.source rsp
);
  import rbfl_pkg::*;
  `include "refcounted_block_free_list_top_assert.svh"

  localparam int IW     = $clog2(POOL_SIZE);
  localparam int CW     = $clog2(POOL_SIZE + 1);
  localparam int INFO_W = REF_WIDTH + 3;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_OEXEC = 3'd3;
  localparam logic [2:0] S_ERR   = 3'd4;

  localparam logic [REF_WIDTH-1:0] REF_MAX = {REF_WIDTH{1'b1}};
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SIZE - 1);

  logic [2:0]        state, state_next;
  logic [IW-1:0]     init_idx;
  logic [FUNC_W-1:0] op;
  logic [BLK_W-1:0]  blk_q;
  logic [CNT_W-1:0]  remain, remain_next;
  logic [IW-1:0]     head, head_next, tail, tail_next;
  logic [CW-1:0]     free_total, total_next;
  rsp_t              err_q, err_next;
  rsp_t              rsp_q, rsp_next;
  logic              rsp_v, rsp_load;
  logic              emit, latch;

  logic              info_we, next_we, prev_we;
  logic [IW-1:0]     info_wa, next_wa, prev_wa, rd_addr;
  logic [INFO_W-1:0] info_wd, info_rd;
  logic [IW-1:0]     next_wd, prev_wd, next_rd, prev_rd;

  logic [REF_WIDTH-1:0] cur_ref, new_ref;
  logic                 cur_used, cur_pin, cur_free;
  logic [IW-1:0]        blk_a;
  logic                 req_in_range;

  assign emit      = !rsp_v || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_v;
  assign rsp.data  = rsp_q;

  assign cur_ref  = info_rd[INFO_W-1:3];
  assign cur_used = info_rd[2];
  assign cur_pin  = info_rd[1];
  assign cur_free = info_rd[0];
  assign blk_a    = IW'(blk_q);
  assign req_in_range = 32'(req.data.block_index) < POOL_SIZE;

  // shared read address for the three memories
  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = (req.data.func == FUNC_ALLOC) ? head : IW'(req.data.block_index);
      S_ALLOC: rd_addr = emit ? next_rd : head;
      default: rd_addr = blk_a;
    endcase
  end

  // sequencer and update unit
  always_comb begin
    state_next  = state;
    remain_next = remain;
    head_next   = head;
    tail_next   = tail;
    total_next  = free_total;
    err_next    = err_q;
    latch       = 1'b0;
    rsp_load    = 1'b0;
    rsp_next    = rsp_q;
    info_we = 1'b0; info_wa = blk_a; info_wd = info_rd;
    next_we = 1'b0; next_wa = blk_a; next_wd = next_rd;
    prev_we = 1'b0; prev_wa = blk_a; prev_wd = prev_rd;
    new_ref = cur_ref;
    unique case (state)
      S_INIT: begin
        info_we = 1'b1; info_wa = init_idx; info_wd = {{REF_WIDTH{1'b0}}, 3'b001};
        next_we = 1'b1; next_wa = init_idx;
        next_wd = (init_idx == LAST_IDX) ? '0 : init_idx + IW'(1);
        prev_we = 1'b1; prev_wa = init_idx;
        prev_wd = (init_idx == '0) ? LAST_IDX : init_idx - IW'(1);
        if (init_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          latch       = 1'b1;
          remain_next = req.data.alloc_count;
          err_next    = '{granted_block: '0, refs_after: '0,
                          free_blocks: FREE_W'(free_total), status: STAT_RANGE, last: 1'b1};
          if (req.data.func == FUNC_ALLOC) begin
            if (req.data.alloc_count == '0 || 32'(req.data.alloc_count) > MAX_ALLOC) begin
              state_next = S_ERR;
            end else if (32'(req.data.alloc_count) > 32'(free_total)) begin
              err_next.status = STAT_NO_FREE;
              state_next = S_ERR;
            end else begin
              state_next = S_ALLOC;
            end
          end else if (req.data.func > FUNC_UNPIN) begin
            state_next = S_ERR;
          end else if (!req_in_range) begin
            err_next.granted_block = req.data.block_index;
            state_next = S_ERR;
          end else begin
            state_next = S_OEXEC;
          end
        end
      end
      S_ALLOC: begin
        if (emit) begin
          info_we = 1'b1; info_wa = head;
          info_wd = {REF_WIDTH'(1), 3'b100};
          head_next   = next_rd;
          total_next  = free_total - CW'(1);
          remain_next = remain - CNT_W'(1);
          rsp_load    = 1'b1;
          // every result reports the length after the whole alloc
          rsp_next    = '{granted_block: BLK_W'(head), refs_after: REFO_W'(1),
                          free_blocks: FREE_W'(free_total - CW'(remain)), status: STAT_OK,
                          last: (remain == CNT_W'(1))};
          if (remain == CNT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      S_OEXEC: begin
        rsp_next = '{granted_block: blk_q, refs_after: '0,
                     free_blocks: '0, status: STAT_OK, last: 1'b1};
        unique case (op)
          FUNC_CLAIM: begin
            if (!cur_free) begin
              rsp_next.status = STAT_NOT_OWN;
            end else begin
              new_ref = REF_WIDTH'(1);
              info_we = 1'b1; info_wd = {new_ref, 1'b1, cur_pin, 1'b0};
              if (blk_a == head) begin
                head_next = next_rd;
              end else begin
                next_we = 1'b1; next_wa = prev_rd; next_wd = next_rd;
              end
              if (blk_a == tail) begin
                tail_next = prev_rd;
              end else begin
                prev_we = 1'b1; prev_wa = next_rd; prev_wd = prev_rd;
              end
              total_next = free_total - CW'(1);
            end
          end
          FUNC_SHARE: begin
            if (!cur_used) begin
              rsp_next.status = STAT_NOT_OWN;
            end else if (cur_pin) begin
              rsp_next.status = STAT_PINNED;
            end else if (cur_ref == REF_MAX) begin
              rsp_next.status = STAT_OVERFLOW;
            end else begin
              new_ref = cur_ref + REF_WIDTH'(1);
              info_we = 1'b1; info_wd = {new_ref, cur_used, cur_pin, cur_free};
            end
          end
          FUNC_RELEASE: begin
            if (!cur_used || cur_ref == '0) begin
              rsp_next.status = STAT_NOT_OWN;
            end else if (cur_pin) begin
              rsp_next.status = STAT_PINNED;
            end else begin
              new_ref = cur_ref - REF_WIDTH'(1);
              info_we = 1'b1; info_wd = {new_ref, cur_used, cur_pin, cur_free};
              if (new_ref == '0) begin
                // count hit zero: append at the tail
                info_wd = {new_ref, 1'b0, cur_pin, 1'b1};
                if (free_total == '0) begin
                  head_next = blk_a;
                end else begin
                  next_we = 1'b1; next_wa = tail; next_wd = blk_a;
                end
                prev_we = 1'b1; prev_wa = blk_a; prev_wd = tail;
                tail_next  = blk_a;
                total_next = free_total + CW'(1);
              end
            end
          end
          FUNC_PIN: begin
            if (!cur_used) begin
              rsp_next.status = STAT_NOT_OWN;
            end else begin
              info_we = 1'b1; info_wd = {cur_ref, cur_used, 1'b1, cur_free};
            end
          end
          default: begin
            if (!cur_used) begin
              rsp_next.status = STAT_NOT_OWN;
            end else begin
              info_we = 1'b1; info_wd = {cur_ref, cur_used, 1'b0, cur_free};
            end
          end
        endcase
        rsp_next.refs_after  = REFO_W'(new_ref);
        rsp_next.free_blocks = FREE_W'(total_next);
        if (emit) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          // stalled: commit nothing
          info_we = 1'b0; next_we = 1'b0; prev_we = 1'b0;
          head_next = head; tail_next = tail; total_next = free_total;
        end
      end
      default: begin
        rsp_next = err_q;
        if (emit) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // control and list registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_idx   <= '0;
      head       <= '0;
      tail       <= LAST_IDX;
      free_total <= CW'(POOL_SIZE);
      rsp_v      <= 1'b0;
      remain     <= '0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      free_total <= total_next;
      remain     <= remain_next;
      if (state == S_INIT) begin
        init_idx <= init_idx + IW'(1);
      end
      if (rsp_load) begin
        rsp_v <= 1'b1;
      end else if (rsp.ready) begin
        rsp_v <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (latch) begin
      op    <= req.data.func;
      blk_q <= req.data.block_index;
      err_q <= err_next;
    end
    if (rsp_load) begin
      rsp_q <= rsp_next;
    end
  end

  rbfl_ram #(.W(INFO_W), .D(POOL_SIZE)) u_info (
    .clk(clk), .we(info_we), .waddr(info_wa), .wdata(info_wd),
    .raddr(rd_addr), .rdata(info_rd)
  );
  rbfl_ram #(.W(IW), .D(POOL_SIZE)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(rd_addr), .rdata(next_rd)
  );
  rbfl_ram #(.W(IW), .D(POOL_SIZE)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(rd_addr), .rdata(prev_rd)
  );

  // checks
  `RBFL_ASSERT_NOW(a_total_bound, 1'b1, 32'(free_total) <= POOL_SIZE)
  `RBFL_ASSERT_NOW(a_alloc_remain, state == S_ALLOC, remain != '0)
  `RBFL_ASSERT_NXT(a_alloc_takes_one, state == S_ALLOC && emit,
                   free_total == $past(free_total) - CW'(1))
endmodule

// File: tb/sv/tb_top.sv
// testbench for the reference counted block free list allocator
// depends on rbfl_pkg, rbfl_stream_if and refcounted_block_free_list_top
`timescale 1ns / 100ps

module tb_top;
  import rbfl_pkg::*;

  localparam int NBLK    = 1024;
  localparam int MAXA    = 16;
  localparam int REF_TOP = 255;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rbfl_stream_if #(.T(req_t)) req_ch ();
  rbfl_stream_if #(.T(rsp_t)) rsp_ch ();

  refcounted_block_free_list_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always #5 clk = ~clk;

  // allocator state mirror
  int unsigned blk_refs [NBLK];
  bit          blk_used [NBLK];
  bit          blk_pinned [NBLK];
  bit          blk_free [NBLK];
  int unsigned nxt [NBLK];
  int unsigned prv [NBLK];
  int unsigned head_q, tail_q, free_cnt;

  req_t pending_ops [$];
  rsp_t expected_rsp [$];
  int   errors = 0;
  int   ops_done = 0;
  int   rsp_seen = 0;
  bit   stim_done = 0;
  int   hold_cycles = 0;

  // shadow list of blocks that have been claimed or allocated, used to aim stimulus
  int unsigned owned [$];

  function automatic void push_rsp(int unsigned blk, int unsigned refs,
                                   logic [ST_W-1:0] st, bit lst);
    rsp_t r;
    r.granted_block = blk[BLK_W-1:0];
    r.refs_after    = refs[REFO_W-1:0];
    r.free_blocks   = free_cnt[FREE_W-1:0];
    r.status        = st;
    r.last          = lst;
    expected_rsp.insert(expected_rsp.size(), r);
  endfunction

  function automatic void unlink_blk(int unsigned b);
    if (b == head_q) head_q = nxt[b]; else nxt[prv[b]] = nxt[b];
    if (b == tail_q) tail_q = prv[b]; else prv[nxt[b]] = prv[b];
    blk_free[b] = 0;
    free_cnt--;
    blk_refs[b] = 1;
    blk_used[b] = 1;
  endfunction

  function automatic void predict_op(req_t rq);
    int unsigned b;
    int unsigned c;
    int unsigned got [$];
    logic [ST_W-1:0] st;
    b = rq.block_index;
    c = rq.alloc_count;
    st = STAT_OK;
    if (rq.func == FUNC_ALLOC) begin
      if (c == 0 || c > MAXA) begin
        push_rsp(0, 0, STAT_RANGE, 1);
      end else if (c > free_cnt) begin
        push_rsp(0, 0, STAT_NO_FREE, 1);
      end else begin
        for (int i = 0; i < c; i++) begin
          got.insert(got.size(), head_q);
          unlink_blk(head_q);
        end
        for (int i = 0; i < c; i++) push_rsp(got[i], 1, STAT_OK, i == c - 1);
      end
      return;
    end
    if (rq.func > FUNC_UNPIN) begin
      push_rsp(0, 0, STAT_RANGE, 1);
      return;
    end
    case (rq.func)
      FUNC_CLAIM: begin
        if (!blk_free[b]) st = STAT_NOT_OWN; else unlink_blk(b);
      end
      FUNC_SHARE: begin
        if (!blk_used[b]) st = STAT_NOT_OWN;
        else if (blk_pinned[b]) st = STAT_PINNED;
        else if (blk_refs[b] >= REF_TOP) st = STAT_OVERFLOW;
        else blk_refs[b]++;
      end
      FUNC_RELEASE: begin
        if (!blk_used[b] || blk_refs[b] == 0) st = STAT_NOT_OWN;
        else if (blk_pinned[b]) st = STAT_PINNED;
        else begin
          blk_refs[b]--;
          if (blk_refs[b] == 0) begin
            blk_used[b] = 0;
            if (free_cnt == 0) head_q = b;
            else begin
              nxt[tail_q] = b;
              prv[b] = tail_q;
            end
            tail_q = b;
            blk_free[b] = 1;
            free_cnt++;
          end
        end
      end
      FUNC_PIN: begin
        if (!blk_used[b]) st = STAT_NOT_OWN; else blk_pinned[b] = 1;
      end
      default: begin
        if (!blk_used[b]) st = STAT_NOT_OWN; else blk_pinned[b] = 0;
      end
    endcase
    push_rsp(b, blk_refs[b], st, 1);
  endfunction

  function automatic void queue_op(logic [FUNC_W-1:0] f, int unsigned b, int unsigned c);
    req_t rq;
    rq.func = f;
    rq.block_index = b[BLK_W-1:0];
    rq.alloc_count = c[CNT_W-1:0];
    pending_ops.insert(pending_ops.size(), rq);
  endfunction

  function automatic int unsigned pick_block();
    if (owned.size() > 0 && $urandom_range(0, 9) < 8)
      return owned[$urandom_range(0, owned.size() - 1)];
    return $urandom_range(0, NBLK - 1);
  endfunction

  // stimulus: directed corner cases then random mix aimed at owned blocks
  initial begin
    for (int i = 0; i < NBLK; i++) begin
      blk_refs[i] = 0;
      blk_used[i] = 0;
      blk_pinned[i] = 0;
      blk_free[i] = 1;
      nxt[i] = (i + 1) % NBLK;
      prv[i] = (i + NBLK - 1) % NBLK;
    end
    head_q = 0;
    tail_q = NBLK - 1;
    free_cnt = NBLK;

    queue_op(FUNC_ALLOC, 0, 0);
    queue_op(FUNC_ALLOC, 0, 17);
    queue_op(FUNC_ALLOC, 0, 31);
    queue_op(FUNC_ALLOC, 1023, 1);
    queue_op(FUNC_ALLOC, 0, 16);
    queue_op(FUNC_CLAIM, 1023, 0);
    queue_op(FUNC_CLAIM, 500, 0);
    queue_op(FUNC_CLAIM, 3, 0);
    queue_op(FUNC_SHARE, 3, 0);
    queue_op(FUNC_PIN, 3, 0);
    queue_op(FUNC_PIN, 3, 0);
    queue_op(FUNC_SHARE, 3, 0);
    queue_op(FUNC_RELEASE, 3, 0);
    queue_op(FUNC_UNPIN, 3, 0);
    queue_op(FUNC_UNPIN, 3, 0);
    queue_op(FUNC_RELEASE, 3, 0);
    queue_op(FUNC_RELEASE, 3, 0);
    queue_op(FUNC_RELEASE, 3, 0);
    queue_op(FUNC_SHARE, 900, 0);
    queue_op(FUNC_PIN, 900, 0);
    queue_op(FUNC_UNPIN, 900, 0);
    queue_op(3'd6, 1023, 31);
    queue_op(3'd7, 0, 5);
    queue_op(FUNC_RELEASE, 1023, 0);
    queue_op(FUNC_RELEASE, 500, 0);
    // random part
    for (int n = 0; n < 190; n++) begin
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 20) queue_op(FUNC_ALLOC, $urandom, $urandom_range(1, 16));
      else if (sel < 23) queue_op(FUNC_ALLOC, $urandom, $urandom_range(0, 31));
      else if (sel < 30) queue_op(FUNC_CLAIM, $urandom_range(0, NBLK - 1), $urandom);
      else if (sel < 50) queue_op(FUNC_SHARE, 0, $urandom);
      else if (sel < 75) queue_op(FUNC_RELEASE, 0, $urandom);
      else if (sel < 85) queue_op(FUNC_PIN, 0, $urandom);
      else if (sel < 97) queue_op(FUNC_UNPIN, 0, $urandom);
      else queue_op(FUNC_W'($urandom_range(6, 7)), $urandom, $urandom);
      // targeted ops get a block chosen when driven, flagged by index 0 here
    end
    // drain the pool to hit no-free, then give some back
    for (int i = 0; i < 66; i++) queue_op(FUNC_ALLOC, 0, 16);
    for (int i = 0; i < 20; i++) queue_op(FUNC_RELEASE, 0, 0);
  end

  // driver: one op at a time with random gaps; block target picked late
  int   gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      gap <= $urandom_range(0, 5);
    end else if (req_ch.valid && !req_ch.ready) begin
      // hold the offered item
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_op(req_ch.data);
        ops_done <= ops_done + 1;
        if (req_ch.data.func == FUNC_CLAIM && blk_used[req_ch.data.block_index])
          owned.insert(owned.size(), req_ch.data.block_index);
      end
      if (gap > 0 || pending_ops.size() == 0) begin
        req_ch.valid <= 1'b0;
        if (gap > 0) gap <= gap - 1;
        if (pending_ops.size() == 0 && ops_done > 0) stim_done <= 1'b1;
      end else begin
        req_t rq;
        rq = pending_ops.pop_front();
        if (rq.func >= FUNC_SHARE && rq.func <= FUNC_UNPIN && rq.block_index == 0)
          rq.block_index = pick_block();
        req_ch.data  <= rq;
        req_ch.valid <= 1'b1;
        gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      end
    end
  end

  // receiver stall control, with one long hold-off early in the run
  int rgap = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rgap <= 0;
    end else if (ops_done >= 40 && ops_done < 60 && hold_cycles < 200) begin
      hold_cycles <= hold_cycles + 1;
      rsp_ch.ready <= 1'b0;
    end else if (rgap > 0) begin
      rgap <= rgap - 1;
      rsp_ch.ready <= 1'b0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      int unsigned w;
      // wait drawn per transfer, 0 keeps ready high
      w = $urandom_range(0, 5);
      rsp_ch.ready <= (w == 0);
      rgap <= (w == 0) ? 0 : int'(w) - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // monitor: compare every result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_t e;
      rsp_t a;
      a = rsp_ch.data;
      rsp_seen <= rsp_seen + 1;
      // alloc results return to the owned pool
      if (a.status == STAT_OK && a.refs_after == 1 && blk_used[a.granted_block])
        owned.insert(owned.size(), a.granted_block);
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, a);
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (e.granted_block !== a.granted_block)
          $display("%0t: granted_block expected %0d actual %0d", $time,
                   e.granted_block, a.granted_block);
        if (e.refs_after !== a.refs_after)
          $display("%0t: refs_after expected %0d actual %0d", $time,
                   e.refs_after, a.refs_after);
        if (e.free_blocks !== a.free_blocks)
          $display("%0t: free_blocks expected %0d actual %0d", $time,
                   e.free_blocks, a.free_blocks);
        if (e.status !== a.status)
          $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        if (e.last !== a.last)
          $display("%0t: last expected %0d actual %0d", $time, e.last, a.last);
        if (e !== a) errors++;
      end
    end
  end

  // reset, then wait for drain and report
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && !req_ch.valid);
    wait (expected_rsp.size() == 0);
    repeat (40) @(posedge clk);
    $display("ran %0d operations, %0d results checked, %0d free at end",
             ops_done, rsp_seen, free_cnt);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // timeout guard
  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
